[design/priority_job_queue_core_macros.svh]
// Assertion macros shared by the job queue RTL.
`ifndef PRIORITY_JOB_QUEUE_CORE_MACROS_SVH
`define PRIORITY_JOB_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PJQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PJQ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pjq_pkg.sv]
// Types and codes of the priority job queue.
package pjq_pkg;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_POP   = 3'd1;
   localparam logic [2:0] OP_USER  = 3'd2;
   localparam logic [2:0] OP_FIT   = 3'd3;
   localparam logic [2:0] OP_ALL   = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;

   localparam logic [2:0] ST_RECORD  = 3'd0;
   localparam logic [2:0] ST_ADDED   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_CLEARED = 3'd4;

   // last member sits in the lowest bits
   typedef struct packed {
      logic signed [15:0] prio;
      logic [15:0]        run_time;
      logic [15:0]        mem_amount;
      logic [7:0]         gpus;
      logic [7:0]         cpus;
      logic [15:0]        user_tag;
      logic [15:0]        job_tag;
   } entry_type;

endpackage

[design/pjq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pjq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[design/priority_job_queue_core.sv]
// Priority job queue: sorted job table in one RAM, walked by a sequencer.
// One request at a time; each entry touched takes a RAM read and then a check or write.
// Add walks back from the tail, shifting entries down until the job's slot is found;
// pop reads the head and shifts the rest up; queries scan every entry; clear, full, empty touch none.
// A query streams each hit one entry behind the scan for tlast.
// Synchronous active-high reset empties the table and drops any result in flight.
`include "priority_job_queue_core_macros.svh"
module priority_job_queue_core
   import pjq_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // job_tag, user_tag, cpus, gpus, mem_amount, run_time, prio (lowest first)
   input  logic [95:0] req_tdata,
   // op
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_job_tag, out_user_tag, out_cpus, out_gpus, out_mem, out_time, out_prio
   output logic [95:0] rsp_tdata,
   // status
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ADD_RD  = 4'd1;
   localparam logic [3:0] S_ADD_CHK = 4'd2;
   localparam logic [3:0] S_ADD_PUT = 4'd3;
   localparam logic [3:0] S_POP_RD  = 4'd4;
   localparam logic [3:0] S_POP_CAP = 4'd5;
   localparam logic [3:0] S_SH_RD   = 4'd6;
   localparam logic [3:0] S_SH_WR   = 4'd7;
   localparam logic [3:0] S_Q_RD    = 4'd8;
   localparam logic [3:0] S_Q_CHK   = 4'd9;
   localparam logic [3:0] S_Q_END   = 4'd10;
   localparam logic [3:0] S_RESP    = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [2:0]    op_ff, op_in;
   entry_type     key_ff, key_in;
   entry_type     res_ff, res_in;
   logic [2:0]    res_st_ff, res_st_in;
   logic          pend_vld_ff, pend_vld_in;
   entry_type     pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   entry_type     rsp_data_ff, rsp_data_in;
   logic [2:0]    rsp_st_ff, rsp_st_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   entry_type     rd_data;
   logic          can_emit;
   logic          emit;
   entry_type     emit_data;
   logic [2:0]    emit_st;
   logic          emit_last;
   logic          hit;

   pjq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign can_emit   = !rsp_valid_ff || rsp_tready;

   // query match against the entry just read
   always_comb begin
      case (op_ff)
         OP_USER: hit = (rd_data.user_tag == key_ff.user_tag);
         OP_FIT:  hit = (rd_data.cpus <= key_ff.cpus) && (rd_data.gpus <= key_ff.gpus) &&
                        (rd_data.mem_amount <= key_ff.mem_amount) &&
                        (rd_data.run_time <= key_ff.run_time);
         default: hit = 1'b1;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      res_in      = res_ff;
      res_st_in   = res_st_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = key_ff;
      emit        = 1'b0;
      emit_data   = res_ff;
      emit_st     = res_st_ff;
      emit_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in = req_tdata;
               op_in  = req_tuser;
               res_in = '0;
               case (req_tuser)
                  OP_ADD: begin
                     if (cnt_ff == FULL_CNT) begin
                        res_st_in = ST_FULL;
                        state_in  = S_RESP;
                     end else if (cnt_ff == '0) begin
                        idx_in   = '0;
                        state_in = S_ADD_PUT;
                     end else begin
                        // walk back from the tail
                        idx_in   = AW'(cnt_ff - CW'(1));
                        state_in = S_ADD_RD;
                     end
                  end
                  OP_POP: begin
                     if (cnt_ff == '0) begin
                        res_st_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        idx_in   = '0;
                        state_in = S_POP_RD;
                     end
                  end
                  OP_USER, OP_FIT, OP_ALL: begin
                     if (cnt_ff == '0) begin
                        res_st_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        idx_in      = '0;
                        pend_vld_in = 1'b0;
                        state_in    = S_Q_RD;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in    = '0;
                     res_st_in = ST_CLEARED;
                     state_in  = S_RESP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_CHK;
         end
         S_ADD_CHK: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + AW'(1);
            if (rd_data.prio >= key_ff.prio) begin
               // new job lands right behind this entry
               wr_data   = key_ff;
               cnt_in    = cnt_ff + CW'(1);
               res_st_in = ST_ADDED;
               state_in  = S_RESP;
            end else begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_ADD_PUT;
               end else begin
                  idx_in   = idx_ff - AW'(1);
                  state_in = S_ADD_RD;
               end
            end
         end
         S_ADD_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            wr_data   = key_ff;
            cnt_in    = cnt_ff + CW'(1);
            res_st_in = ST_ADDED;
            state_in  = S_RESP;
         end
         S_POP_RD: begin
            state_in = S_POP_CAP;
         end
         S_POP_CAP: begin
            res_in    = rd_data;
            res_st_in = ST_RECORD;
            cnt_in    = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_RESP;
            end else begin
               idx_in   = AW'(1);
               state_in = S_SH_RD;
            end
         end
         S_SH_RD: begin
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            // cnt_ff already holds the new count, equal to the last old index
            wr_en   = 1'b1;
            wr_addr = idx_ff - AW'(1);
            wr_data = rd_data;
            if (CW'(idx_ff) == cnt_ff) begin
               state_in = S_RESP;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_SH_RD;
            end
         end
         S_Q_RD: begin
            state_in = S_Q_CHK;
         end
         S_Q_CHK: begin
            // read address holds, so the entry stays put during an output stall
            if (!(hit && pend_vld_ff && !can_emit)) begin
               if (hit) begin
                  if (pend_vld_ff) begin
                     emit      = 1'b1;
                     emit_data = pend_ff;
                     emit_st   = ST_RECORD;
                     emit_last = 1'b0;
                  end
                  pend_in     = rd_data;
                  pend_vld_in = 1'b1;
               end
               if (CW'(idx_ff) == cnt_ff - CW'(1)) begin
                  state_in = S_Q_END;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_Q_RD;
               end
            end
         end
         S_Q_END: begin
            if (can_emit) begin
               emit        = 1'b1;
               emit_data   = pend_vld_ff ? pend_ff : '0;
               emit_st     = pend_vld_ff ? ST_RECORD : ST_EMPTY;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         S_RESP: begin
            if (can_emit) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: load on emit, drop once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
         rsp_st_in    = emit_st;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      res_st_ff   <= res_st_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tlast  = rsp_last_ff;

   `PJQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= FULL_CNT, "entry count above table depth")
   `PJQ_ASSERT_IMP(a_idle_no_pend, state_ff == S_IDLE, !pend_vld_ff,
                   "held query hit left over in idle")
   `PJQ_ASSERT_NXT(a_clear_empties, req_tvalid && req_tready && req_tuser == OP_CLEAR,
                   cnt_ff == '0, "clear did not empty the table")
   `PJQ_ASSERT_NXT(a_full_drop, req_tvalid && req_tready && req_tuser == OP_ADD &&
                   cnt_ff == FULL_CNT, $stable(cnt_ff), "add to full table changed count")

endmodule
